FILE: hw/rtl/tpuf_pkg.sv
// Shared types and constants for the time-of-flight pixel unpack filter.
// Used by the top level; no dependencies.
`default_nettype none

package tpuf_pkg;

   // Stream payload layout, lowest bit first.
   localparam int unsigned IN_TDATA_W  = 104;
   localparam int unsigned OUT_TDATA_W = 48;

   localparam int unsigned OFF_LUT_INDEX     = 0;
   localparam int unsigned OFF_LUT_VALUE     = 8;
   localparam int unsigned OFF_PIXEL_INDEX   = 24;
   localparam int unsigned OFF_DEPTH_FORMAT  = 41;
   localparam int unsigned OFF_CODE_SHIFT    = 42;
   localparam int unsigned OFF_DEPTH_RAW     = 50;
   localparam int unsigned OFF_IR_FORMAT     = 66;
   localparam int unsigned OFF_IR_RAW        = 67;
   localparam int unsigned OFF_STATUS_FORMAT = 83;
   localparam int unsigned OFF_STATUS_RAW    = 85;

   localparam int unsigned OFF_DEPTH_OUT = 0;
   localparam int unsigned OFF_INTENSITY = 16;
   localparam int unsigned OFF_STATUS    = 32;

   // Field widths.
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned PIX_W     = 17;
   localparam int unsigned SHIFT_W   = 8;
   localparam int unsigned ALPHA_W   = 9;
   localparam int unsigned MASK_W    = 4;
   localparam int unsigned PRODUCT_W = 25;
   localparam int unsigned SUM_W     = 26;

   // Depth lookup table.
   localparam int unsigned LUT_ENTRIES = 256;
   localparam int unsigned LUT_ADDR_W  = 8;

   // History store never exceeds what a 17-bit pixel index can address.
   localparam int unsigned MAX_STORE_DEPTH = 131072;

   localparam logic [SHIFT_W-1:0] SHIFT_LUT   = 8'd255;
   localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 8'd16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;

   // Item kinds carried on tuser.
   localparam logic MODE_LUT_WRITE = 1'b0;
   localparam logic MODE_PIXEL     = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FMT_RAW  = 2'd0,
      STATUS_FMT_2BIT = 2'd1,
      STATUS_FMT_BYTE = 2'd2,
      STATUS_FMT_1BIT = 2'd3
   } status_format_type;

   localparam logic [1:0] STATUS_BAD = 2'd3;

   // Control and status registers.
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_TEMPORAL_ENABLE = 2'd0,
      REG_BLEND_WEIGHT    = 2'd1,
      REG_KEEP_MASK       = 2'd2
   } csr_reg_type;

   localparam logic               ENABLE_RESET = 1'b0;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd128;
   localparam logic [MASK_W-1:0]  KEEP_RESET   = 4'hF;

endpackage

`default_nettype wire

FILE: hw/rtl/tpuf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tpuf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Hold the last read while no new read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tof_pixel_unpack_filter_top.sv
// Time-of-flight pixel unpack filter: depth, intensity and status decode with temporal blend.
// Pipeline: three stages, then an output register with a skid stage drives rsp_tvalid.
// Throughput: one transaction per cycle while the skid stage is empty; a blending pixel
//   waits while an older same-index pixel is in stages 1-3, ahead of the history write-back.
// Reset: synchronous, active high; clears valids, registers (0/128/15) and the history flag;
//   depth table and history memory are left as they are. Depends on tpuf_pkg and tpuf_ram.
`default_nettype none

module tof_pixel_unpack_filter_top #(
   parameter int unsigned FRAME_WIDTH  = 320,
   parameter int unsigned FRAME_HEIGHT = 240
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   // Input stream.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata, low bit up: lut_index[8], lut_value[16], pixel_index[17], depth_format[1],
   //   code_shift[8], depth_raw[16], ir_format[1], ir_raw[16], status_format[2],
   //   status_raw[16], zero pad[3]
   input  wire logic [tpuf_pkg::IN_TDATA_W-1:0]       req_tdata,
   // tuser: mode[1] (0 table write, 1 pixel)
   input  wire logic                                  req_tuser,

   // Result stream.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata, low bit up: depth_out[16], intensity[16], status[16]
   output logic      [tpuf_pkg::OUT_TDATA_W-1:0]      rsp_tdata,

   // Register port.
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [tpuf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [tpuf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic      [tpuf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                       csr_pready
);

   // ---------------------------------------------------------------------------------------
   // Frame geometry
   // ---------------------------------------------------------------------------------------
   localparam int unsigned PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int unsigned STORE_DEPTH = (PIXEL_COUNT < tpuf_pkg::MAX_STORE_DEPTH) ?
                                         PIXEL_COUNT : tpuf_pkg::MAX_STORE_DEPTH;
   localparam int unsigned STORE_ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned LAST_PIXEL   = PIXEL_COUNT - 1;

   localparam int unsigned WORD_W  = tpuf_pkg::WORD_W;
   localparam int unsigned CODE_W  = tpuf_pkg::CODE_W;
   localparam int unsigned ALPHA_W = tpuf_pkg::ALPHA_W;
   localparam int unsigned PROD_W  = tpuf_pkg::PRODUCT_W;
   localparam int unsigned SUM_W   = tpuf_pkg::SUM_W;

   // ---------------------------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------------------------
   logic                              enable_ff, enable_in;
   logic [ALPHA_W-1:0]                alpha_ff, alpha_in;
   logic [tpuf_pkg::MASK_W-1:0]       keep_ff, keep_in;
   logic                              history_ff, history_in;
   logic                              csr_write;
   tpuf_pkg::csr_reg_type             csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = tpuf_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg)
         tpuf_pkg::REG_TEMPORAL_ENABLE: csr_prdata[0] = enable_ff;
         tpuf_pkg::REG_BLEND_WEIGHT:    csr_prdata[ALPHA_W-1:0] = alpha_ff;
         tpuf_pkg::REG_KEEP_MASK:       csr_prdata[tpuf_pkg::MASK_W-1:0] = keep_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Input field unpack
   // ---------------------------------------------------------------------------------------
   logic [tpuf_pkg::LUT_ADDR_W-1:0]   in_lut_index;
   logic [WORD_W-1:0]                 in_lut_value;
   logic [tpuf_pkg::PIX_W-1:0]        in_pixel_index;
   logic                              in_depth_format;
   logic [tpuf_pkg::SHIFT_W-1:0]      in_code_shift;
   logic [WORD_W-1:0]                 in_depth_raw;
   logic                              in_ir_format;
   logic [WORD_W-1:0]                 in_ir_raw;
   tpuf_pkg::status_format_type       in_status_format;
   logic [WORD_W-1:0]                 in_status_raw;

   assign in_lut_index     = req_tdata[tpuf_pkg::OFF_LUT_INDEX +: tpuf_pkg::LUT_ADDR_W];
   assign in_lut_value     = req_tdata[tpuf_pkg::OFF_LUT_VALUE +: WORD_W];
   assign in_pixel_index   = req_tdata[tpuf_pkg::OFF_PIXEL_INDEX +: tpuf_pkg::PIX_W];
   assign in_depth_format  = req_tdata[tpuf_pkg::OFF_DEPTH_FORMAT];
   assign in_code_shift    = req_tdata[tpuf_pkg::OFF_CODE_SHIFT +: tpuf_pkg::SHIFT_W];
   assign in_depth_raw     = req_tdata[tpuf_pkg::OFF_DEPTH_RAW +: WORD_W];
   assign in_ir_format     = req_tdata[tpuf_pkg::OFF_IR_FORMAT];
   assign in_ir_raw        = req_tdata[tpuf_pkg::OFF_IR_RAW +: WORD_W];
   assign in_status_format =
      tpuf_pkg::status_format_type'(req_tdata[tpuf_pkg::OFF_STATUS_FORMAT +: 2]);
   assign in_status_raw    = req_tdata[tpuf_pkg::OFF_STATUS_RAW +: WORD_W];

   // In-frame pixels store when enabled and blend once history is set; others are only decoded.
   logic                              in_is_pixel;
   logic                              in_in_frame;
   logic                              in_store;
   logic                              in_blend;
   logic                              in_frame_end;
   logic [STORE_ADDR_W-1:0]           in_addr;

   assign in_is_pixel  = (req_tuser == tpuf_pkg::MODE_PIXEL);
   assign in_in_frame  = (32'(in_pixel_index) < 32'(STORE_DEPTH));
   assign in_store     = in_is_pixel & enable_ff & in_in_frame;
   assign in_blend     = in_store & history_ff;
   assign in_frame_end = (32'(in_pixel_index) == 32'(LAST_PIXEL));
   assign in_addr      = in_pixel_index[STORE_ADDR_W-1:0];

   // ---------------------------------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------------------------------
   // Whole pipeline advances while the output skid stage is empty.
   logic                              advance;
   logic                              hazard;
   logic                              accept;

   logic                              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                              s1_store_ff, s2_store_ff, s3_store_ff;
   logic [STORE_ADDR_W-1:0]           s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic                              skid_valid_ff;

   // A blending pixel must not read history that an older in-flight pixel will rewrite.
   assign hazard = in_blend &
                   ((s1_valid_ff & s1_store_ff & (s1_addr_ff == in_addr)) |
                    (s2_valid_ff & s2_store_ff & (s2_addr_ff == in_addr)) |
                    (s3_valid_ff & s3_store_ff & (s3_addr_ff == in_addr)));

   assign advance    = ~skid_valid_ff;
   assign req_tready = advance & ~hazard;
   assign accept     = req_tvalid & req_tready;

   // History flag and registers: any write to enable or alpha drops history.
   always_comb begin
      enable_in  = enable_ff;
      alpha_in   = alpha_ff;
      keep_in    = keep_ff;
      history_in = history_ff;
      if (csr_write) begin
         unique case (csr_reg)
            tpuf_pkg::REG_TEMPORAL_ENABLE: begin
               enable_in  = csr_pwdata[0];
               history_in = 1'b0;
            end
            tpuf_pkg::REG_BLEND_WEIGHT: begin
               alpha_in   = csr_pwdata[ALPHA_W-1:0];
               history_in = 1'b0;
            end
            tpuf_pkg::REG_KEEP_MASK: begin
               keep_in    = csr_pwdata[tpuf_pkg::MASK_W-1:0];
            end
            default: begin
               history_in = history_ff;
            end
         endcase
      end else if (accept & in_store & in_frame_end) begin
         history_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= tpuf_pkg::ENABLE_RESET;
         alpha_ff   <= tpuf_pkg::ALPHA_RESET;
         keep_ff    <= tpuf_pkg::KEEP_RESET;
         history_ff <= 1'b0;
      end else begin
         enable_ff  <= enable_in;
         alpha_ff   <= alpha_in;
         keep_ff    <= keep_in;
         history_ff <= history_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Memories: depth table and previous-frame depth
   // ---------------------------------------------------------------------------------------
   logic [WORD_W-1:0]                 lut_rd_data;
   logic [WORD_W-1:0]                 hist_rd_data;
   logic                              hist_wr_en;
   logic [WORD_W-1:0]                 s3_blended;

   // Table writes go in at acceptance; a later pixel reads at its own acceptance.
   tpuf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (tpuf_pkg::LUT_ENTRIES),
      .ADDR_W(tpuf_pkg::LUT_ADDR_W)
   ) u_lut_ram (
      .clock  (clock),
      .wr_en  (accept & (req_tuser == tpuf_pkg::MODE_LUT_WRITE)),
      .wr_addr(in_lut_index),
      .wr_data(in_lut_value),
      .rd_en  (accept),
      .rd_addr(in_depth_raw[CODE_W-1:0]),
      .rd_data(lut_rd_data)
   );

   assign hist_wr_en = advance & s3_valid_ff & s3_store_ff;

   tpuf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH),
      .ADDR_W(STORE_ADDR_W)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (hist_wr_en),
      .wr_addr(s3_addr_ff),
      .wr_data(s3_blended),
      .rd_en  (accept),
      .rd_addr(in_addr),
      .rd_data(hist_rd_data)
   );

   // ---------------------------------------------------------------------------------------
   // Stage 1: captured fields, memory reads in flight
   // ---------------------------------------------------------------------------------------
   logic                              s1_depth_format_ff;
   logic [tpuf_pkg::SHIFT_W-1:0]      s1_code_shift_ff;
   logic [WORD_W-1:0]                 s1_depth_raw_ff;
   logic                              s1_ir_format_ff;
   logic [WORD_W-1:0]                 s1_ir_raw_ff;
   tpuf_pkg::status_format_type       s1_status_format_ff;
   logic [WORD_W-1:0]                 s1_status_raw_ff;
   logic [2:0]                        s1_pix_low_ff;
   logic                              s1_blend_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_depth_format_ff  <= in_depth_format;
         s1_code_shift_ff    <= in_code_shift;
         s1_depth_raw_ff     <= in_depth_raw;
         s1_ir_format_ff     <= in_ir_format;
         s1_ir_raw_ff        <= in_ir_raw;
         s1_status_format_ff <= in_status_format;
         s1_status_raw_ff    <= in_status_raw;
         s1_pix_low_ff       <= in_pixel_index[2:0];
         s1_store_ff         <= in_store;
         s1_blend_ff         <= in_blend;
         s1_addr_ff          <= in_addr;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1 -> 2: decode depth, intensity and status
   // ---------------------------------------------------------------------------------------
   logic [WORD_W-1:0]                 s2_depth_in;
   logic [WORD_W-1:0]                 s2_intensity_in;
   logic [WORD_W-1:0]                 s2_status_in;
   logic                              s2_keep_in;
   logic [CODE_W-1:0]                 s1_depth_code;
   logic [CODE_W-1:0]                 s1_status_byte;

   assign s1_depth_code  = s1_depth_raw_ff[CODE_W-1:0];
   assign s1_status_byte = s1_status_raw_ff[CODE_W-1:0];

   always_comb begin
      if (!s1_depth_format_ff) begin
         s2_depth_in = s1_depth_raw_ff;
      end else if (s1_code_shift_ff == tpuf_pkg::SHIFT_LUT) begin
         s2_depth_in = lut_rd_data;
      end else if (s1_code_shift_ff >= tpuf_pkg::SHIFT_LIMIT) begin
         s2_depth_in = '0;
      end else begin
         s2_depth_in = {{(WORD_W-CODE_W){1'b0}}, s1_depth_code} << s1_code_shift_ff[3:0];
      end
   end

   assign s2_intensity_in = s1_ir_format_ff ? {4'b0, s1_ir_raw_ff[CODE_W-1:0], 4'b0}
                                            : s1_ir_raw_ff;

   always_comb begin
      unique case (s1_status_format_ff)
         tpuf_pkg::STATUS_FMT_2BIT:
            s2_status_in = {14'b0, s1_status_byte[{s1_pix_low_ff[1:0], 1'b0} +: 2]};
         tpuf_pkg::STATUS_FMT_BYTE:
            s2_status_in = {8'b0, s1_status_byte};
         tpuf_pkg::STATUS_FMT_1BIT:
            s2_status_in = s1_status_byte[s1_pix_low_ff] ? {14'b0, tpuf_pkg::STATUS_BAD}
                                                          : '0;
         default:
            s2_status_in = s1_status_raw_ff;
      endcase
   end

   // Codes above bad are never kept.
   assign s2_keep_in = (s2_status_in[WORD_W-1:2] == '0) & keep_ff[s2_status_in[1:0]];

   logic [WORD_W-1:0]                 s2_depth_ff;
   logic [WORD_W-1:0]                 s2_prev_ff;
   logic [WORD_W-1:0]                 s2_intensity_ff;
   logic [WORD_W-1:0]                 s2_status_ff;
   logic                              s2_keep_ff;
   logic                              s2_blend_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_depth_ff     <= s2_depth_in;
         // Drop the history word unless blending; its entry may never have been written.
         s2_prev_ff      <= s1_blend_ff ? hist_rd_data : '0;
         s2_intensity_ff <= s2_intensity_in;
         s2_status_ff    <= s2_status_in;
         s2_keep_ff      <= s2_keep_in;
         s2_blend_ff     <= s1_blend_ff;
         s2_store_ff     <= s1_store_ff;
         s2_addr_ff      <= s1_addr_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2 -> 3: blend products (weight 256 on new depth when not blending)
   // ---------------------------------------------------------------------------------------
   logic [ALPHA_W-1:0]                alpha_sat;
   logic [ALPHA_W-1:0]                alpha_eff;
   logic [ALPHA_W-1:0]                alpha_inv;
   logic [PROD_W-1:0]                 s3_new_prod_in;
   logic [PROD_W-1:0]                 s3_old_prod_in;

   assign alpha_sat = (alpha_ff > tpuf_pkg::ALPHA_ONE) ? tpuf_pkg::ALPHA_ONE : alpha_ff;
   assign alpha_eff = s2_blend_ff ? alpha_sat : tpuf_pkg::ALPHA_ONE;
   assign alpha_inv = tpuf_pkg::ALPHA_ONE - alpha_eff;

   assign s3_new_prod_in = PROD_W'(alpha_eff) * PROD_W'(s2_depth_ff);
   assign s3_old_prod_in = PROD_W'(alpha_inv) * PROD_W'(s2_prev_ff);

   logic [PROD_W-1:0]                 s3_new_prod_ff;
   logic [PROD_W-1:0]                 s3_old_prod_ff;
   logic [WORD_W-1:0]                 s3_intensity_ff;
   logic [WORD_W-1:0]                 s3_status_ff;
   logic                              s3_keep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_new_prod_ff  <= s3_new_prod_in;
         s3_old_prod_ff  <= s3_old_prod_in;
         s3_intensity_ff <= s2_intensity_ff;
         s3_status_ff    <= s2_status_ff;
         s3_keep_ff      <= s2_keep_ff;
         s3_store_ff     <= s2_store_ff;
         s3_addr_ff      <= s2_addr_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 3 -> output: sum, truncate, write back, apply keep mask
   // ---------------------------------------------------------------------------------------
   logic [SUM_W-1:0]                  s3_sum;
   logic [tpuf_pkg::OUT_TDATA_W-1:0]  res_data;
   logic                              res_valid;

   assign s3_sum     = SUM_W'(s3_new_prod_ff) + SUM_W'(s3_old_prod_ff);
   assign s3_blended = s3_sum[8 +: WORD_W];
   assign res_valid  = s3_valid_ff & advance;

   always_comb begin
      res_data = '0;
      res_data[tpuf_pkg::OFF_DEPTH_OUT +: WORD_W] = s3_keep_ff ? s3_blended : '0;
      res_data[tpuf_pkg::OFF_INTENSITY +: WORD_W] = s3_intensity_ff;
      res_data[tpuf_pkg::OFF_STATUS +: WORD_W]    = s3_status_ff;
   end

   // Stage valids travel with the data; bubbles enter on no acceptance or table writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept & in_is_pixel;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output register with skid stage
   // ---------------------------------------------------------------------------------------
   logic                              out_valid_ff, out_valid_in;
   logic [tpuf_pkg::OUT_TDATA_W-1:0]  out_data_ff, out_data_in;
   logic                              skid_valid_in;
   logic [tpuf_pkg::OUT_TDATA_W-1:0]  skid_data_ff, skid_data_in;
   logic                              out_take;

   assign out_take = ~out_valid_ff | rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_take) begin
         // Drain the skid first; the pipeline is held while it is full.
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = res_valid;
            out_data_in   = res_data;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tof_pixel_unpack_filter_top: streams depth-table writes and pixels,
// predicts every decoded pixel in-line and compares it with the result stream.
// Depends on tpuf_pkg and the filter RTL only.

module tb;
   import tpuf_pkg::*;

   localparam int unsigned FRAME_W       = 320;
   localparam int unsigned FRAME_H       = 240;
   localparam int unsigned PIXEL_COUNT   = FRAME_W * FRAME_H;
   localparam int unsigned PIX_SPAN      = 1 << PIX_W;
   // Settle time covers the pipeline and any table writes still in flight.
   localparam int unsigned SETTLE_CYCLES = 12;

   // One transaction on the input stream, all fields unpacked.
   typedef struct {
      logic                mode;
      logic [CODE_W-1:0]   lut_index;
      logic [WORD_W-1:0]   lut_value;
      logic [PIX_W-1:0]    pixel_index;
      logic                depth_format;
      logic [SHIFT_W-1:0]  code_shift;
      logic [WORD_W-1:0]   depth_raw;
      logic                ir_format;
      logic [WORD_W-1:0]   ir_raw;
      status_format_type   status_format;
      logic [WORD_W-1:0]   status_raw;
   } sensor_item_type;

   typedef struct {
      logic [WORD_W-1:0] depth_out;
      logic [WORD_W-1:0] intensity;
      logic [WORD_W-1:0] status;
   } pixel_result_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata   = '0;
   logic                   req_tuser   = MODE_LUT_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   tof_pixel_unpack_filter_top #(
      .FRAME_WIDTH  (FRAME_W),
      .FRAME_HEIGHT (FRAME_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Transactions waiting for the driver, and decoded pixels waiting for the monitor.
   sensor_item_type  pending_items [$];
   pixel_result_type pixel_results_due [$];

   // Shadow of the block: depth table, per-pixel history and the three registers.
   logic [WORD_W-1:0]  lut_shadow [LUT_ENTRIES];
   bit                 lut_written [LUT_ENTRIES];
   logic [WORD_W-1:0]  depth_history [PIXEL_COUNT];
   bit                 history_written [PIXEL_COUNT];
   int unsigned        stored_pixels [$];
   bit                 history_armed = 1'b0;
   logic               blend_on      = ENABLE_RESET;
   logic [ALPHA_W-1:0] blend_alpha   = ALPHA_RESET;
   logic [MASK_W-1:0]  keep_bits     = KEEP_RESET;

   int unsigned mismatches        = 0;
   int unsigned sender_idle_pct   = 36;
   int unsigned receiver_idle_pct = 48;
   bit          req_taken         = 1'b0;

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
   endfunction

   // Decode one pixel against the shadow state and advance that state.
   function automatic pixel_result_type decode_pixel(sensor_item_type it);
      pixel_result_type  r;
      logic [31:0]       depth;
      logic [31:0]       wide;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] sbyte;
      logic [WORD_W-1:0] stat;
      int unsigned       pix;
      int unsigned       a;
      code  = it.depth_raw[CODE_W-1:0];
      sbyte = it.status_raw[CODE_W-1:0];
      pix   = 32'(it.pixel_index);

      if (!it.depth_format) begin
         depth = 32'(it.depth_raw);
      end else if (it.code_shift == SHIFT_LUT) begin
         depth = 32'(lut_shadow[code]);
      end else if (it.code_shift >= SHIFT_LIMIT) begin
         depth = '0;
      end else begin
         wide  = 32'(code) << it.code_shift;
         depth = {16'h0, wide[WORD_W-1:0]};
      end

      r.intensity = it.ir_format ? {4'h0, it.ir_raw[CODE_W-1:0], 4'h0} : it.ir_raw;

      case (it.status_format)
         STATUS_FMT_2BIT: stat = WORD_W'((sbyte >> (2 * (pix % 4))) & 8'h03);
         STATUS_FMT_BYTE: stat = WORD_W'(sbyte);
         STATUS_FMT_1BIT: stat = sbyte[pix % 8] ? WORD_W'(STATUS_BAD) : '0;
         default:         stat = it.status_raw;
      endcase

      // Blend and store back only inside the frame; the last pixel arms history.
      if (blend_on && pix < PIXEL_COUNT) begin
         if (history_armed) begin
            a     = (blend_alpha > ALPHA_ONE) ? 32'(ALPHA_ONE) : 32'(blend_alpha);
            // Q8 weights: drop the eight fraction bits, truncate to the word.
            depth = ((a * depth + (32'(ALPHA_ONE) - a) * 32'(depth_history[pix])) >> 8)
                    & 32'h0000_FFFF;
         end
         depth_history[pix] = depth[WORD_W-1:0];
         if (!history_written[pix]) begin
            history_written[pix] = 1'b1;
            stored_pixels.push_back(pix);
         end
         if (pix == PIXEL_COUNT - 1)
            history_armed = 1'b1;
      end

      // Unknown codes are never kept.
      if (stat > WORD_W'(STATUS_BAD) || !keep_bits[stat[1:0]])
         depth = '0;

      r.depth_out = depth[WORD_W-1:0];
      r.status    = stat;
      return r;
   endfunction

   // Queue a transaction for the driver and record what it must produce.
   function automatic void queue_item(sensor_item_type it);
      sensor_item_type fill;
      if (it.mode == MODE_PIXEL) begin
         // Never look up a table entry that holds nothing: write it first.
         if (it.depth_format && it.code_shift == SHIFT_LUT &&
             !lut_written[it.depth_raw[CODE_W-1:0]]) begin
            fill           = it;
            fill.mode      = MODE_LUT_WRITE;
            fill.lut_index = it.depth_raw[CODE_W-1:0];
            fill.lut_value = WORD_W'($urandom);
            queue_item(fill);
         end
         // Never blend against a history entry that was never stored.
         if (blend_on && history_armed && it.pixel_index < PIXEL_COUNT &&
             !history_written[it.pixel_index])
            it.pixel_index =
               PIX_W'(stored_pixels[$urandom_range(0, stored_pixels.size() - 1)]);
         pixel_results_due.push_back(decode_pixel(it));
      end else begin
         lut_shadow[it.lut_index]  = it.lut_value;
         lut_written[it.lut_index] = 1'b1;
      end
      pending_items.push_back(it);
   endfunction

   // Random transaction: mostly pixels, indices clustered so that repeats hit the
   // write-back hazard, shifts weighted toward the lookup and the in-range shifts.
   function automatic sensor_item_type random_item();
      sensor_item_type it;
      int unsigned     pick;
      it.mode      = ($urandom_range(0, 99) < 20) ? MODE_LUT_WRITE : MODE_PIXEL;
      it.lut_index = CODE_W'($urandom);
      it.lut_value = WORD_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10)
         it.pixel_index = PIX_W'($urandom_range(PIXEL_COUNT, PIX_SPAN - 1));
      else if (pick < 16)
         it.pixel_index = PIX_W'(PIXEL_COUNT - 1);
      else if (pick < 56)
         it.pixel_index = PIX_W'($urandom_range(0, 15));
      else
         it.pixel_index = PIX_W'($urandom_range(0, PIXEL_COUNT - 2));
      it.depth_format = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35)
         it.code_shift = SHIFT_LUT;
      else if (pick < 75)
         it.code_shift = SHIFT_W'($urandom_range(0, 15));
      else
         it.code_shift = SHIFT_W'($urandom);
      it.depth_raw     = WORD_W'($urandom);
      it.ir_format     = 1'($urandom);
      it.ir_raw        = WORD_W'($urandom);
      it.status_format = status_format_type'($urandom_range(0, 3));
      // Half the time keep the status word small so the keep mask gets exercised.
      it.status_raw    = ($urandom_range(0, 1) == 0) ? WORD_W'($urandom_range(0, 3))
                                                     : WORD_W'($urandom);
      return it;
   endfunction

   function automatic sensor_item_type lut_item(int unsigned index, int unsigned value);
      sensor_item_type it;
      it               = random_item();
      it.mode          = MODE_LUT_WRITE;
      it.lut_index     = CODE_W'(index);
      it.lut_value     = WORD_W'(value);
      return it;
   endfunction

   function automatic sensor_item_type pixel_item(int unsigned pix, bit dfmt,
                                                  int unsigned shift, int unsigned draw,
                                                  bit ifmt, int unsigned iraw,
                                                  status_format_type sfmt,
                                                  int unsigned sraw);
      sensor_item_type it;
      it               = random_item();
      it.mode          = MODE_PIXEL;
      it.pixel_index   = PIX_W'(pix);
      it.depth_format  = dfmt;
      it.code_shift    = SHIFT_W'(shift);
      it.depth_raw     = WORD_W'(draw);
      it.ir_format     = ifmt;
      it.ir_raw        = WORD_W'(iraw);
      it.status_format = sfmt;
      it.status_raw    = WORD_W'(sraw);
      return it;
   endfunction

   // Driver: present the next queued transaction once the current one is taken.
   always @(posedge clock)
      req_taken <= req_tvalid && req_tready;

   always @(negedge clock) begin : driver
      sensor_item_type       it;
      logic [IN_TDATA_W-1:0] bus_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            it       = pending_items.pop_front();
            bus_word = '0;
            bus_word[OFF_LUT_INDEX     +: CODE_W]  = it.lut_index;
            bus_word[OFF_LUT_VALUE     +: WORD_W]  = it.lut_value;
            bus_word[OFF_PIXEL_INDEX   +: PIX_W]   = it.pixel_index;
            bus_word[OFF_DEPTH_FORMAT]             = it.depth_format;
            bus_word[OFF_CODE_SHIFT    +: SHIFT_W] = it.code_shift;
            bus_word[OFF_DEPTH_RAW     +: WORD_W]  = it.depth_raw;
            bus_word[OFF_IR_FORMAT]                = it.ir_format;
            bus_word[OFF_IR_RAW        +: WORD_W]  = it.ir_raw;
            bus_word[OFF_STATUS_FORMAT +: 2]       = it.status_format;
            bus_word[OFF_STATUS_RAW    +: WORD_W]  = it.status_raw;
            req_tdata  <= bus_word;
            req_tuser  <= it.mode;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);

   // Monitor: compare every accepted result with the oldest decoded pixel.
   always @(posedge clock) begin : monitor
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_results_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = pixel_results_due.pop_front();
            check_field("depth_out", 32'(want.depth_out),
                        32'(rsp_tdata[OFF_DEPTH_OUT +: WORD_W]));
            check_field("intensity", 32'(want.intensity),
                        32'(rsp_tdata[OFF_INTENSITY +: WORD_W]));
            check_field("status", 32'(want.status), 32'(rsp_tdata[OFF_STATUS +: WORD_W]));
         end
      end
   end

   // One register transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic write, input csr_reg_type which,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'({which, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_registers();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, REG_TEMPORAL_ENABLE, '0, rd);
      check_field("temporal_enable", CSR_DATA_W'(blend_on), rd);
      csr_access(1'b0, REG_BLEND_WEIGHT, '0, rd);
      check_field("blend_weight", CSR_DATA_W'(blend_alpha), rd);
      csr_access(1'b0, REG_KEEP_MASK, '0, rd);
      check_field("keep_mask", CSR_DATA_W'(keep_bits), rd);
   endtask

   // Write all three registers; writing enable or alpha drops the history.
   task automatic apply_setting(input logic en, input logic [ALPHA_W-1:0] alpha,
                                input logic [MASK_W-1:0] keep);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, REG_TEMPORAL_ENABLE, CSR_DATA_W'(en), rd);
      csr_access(1'b1, REG_BLEND_WEIGHT, CSR_DATA_W'(alpha), rd);
      csr_access(1'b1, REG_KEEP_MASK, CSR_DATA_W'(keep), rd);
      blend_on      = en;
      blend_alpha   = alpha;
      keep_bits     = keep;
      history_armed = 1'b0;
      check_registers();
   endtask

   // Queue random transactions, then hold the sender until every result is back
   // and the pipeline has emptied of table writes.
   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned count);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) queue_item(random_item());
      while (pending_items.size() != 0 || req_tvalid || pixel_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      check_registers();

      // Decode paths with blending off: table extremes, shift edges, every status
      // format, frame end, pixels past the frame, unknown status codes.
      apply_setting(1'b0, 9'd0, 4'hF);
      queue_item(lut_item(0, 16'h0000));
      queue_item(lut_item(255, 16'hFFFF));
      queue_item(lut_item(8'hA5, 16'h5A3C));
      queue_item(pixel_item(0, 1, SHIFT_LUT, 16'hFF00, 1, 16'hFFFF, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(PIXEL_COUNT - 1, 1, SHIFT_LUT, 16'h00FF, 0, 16'hFFFF,
                            STATUS_FMT_BYTE, 16'hFF03));
      queue_item(pixel_item(PIXEL_COUNT, 1, SHIFT_LUT, 16'h00A5, 1, 0,
                            STATUS_FMT_2BIT, 16'h00E4));
      queue_item(pixel_item(PIX_SPAN - 1, 1, 0, 16'hFFFF, 0, 0, STATUS_FMT_1BIT, 16'h0080));
      queue_item(pixel_item(1, 1, 15, 16'h00FF, 1, 16'h00FF, STATUS_FMT_RAW, 1));
      queue_item(pixel_item(2, 1, 16, 16'h00FF, 0, 0, STATUS_FMT_RAW, 2));
      queue_item(pixel_item(3, 1, 254, 16'h00FF, 0, 0, STATUS_FMT_2BIT, 16'h00C0));
      queue_item(pixel_item(4, 0, 0, 16'hFFFF, 0, 0, STATUS_FMT_RAW, 16'hFFFF));
      queue_item(pixel_item(5, 0, 255, 16'h8001, 1, 0, STATUS_FMT_RAW, 4));
      queue_item(pixel_item(6, 0, 0, 16'h1234, 0, 0, STATUS_FMT_BYTE, 16'h00FF));
      queue_item(pixel_item(7, 1, 4, 16'h3C81, 0, 0, STATUS_FMT_1BIT, 16'h007F));
      run_phase(36, 48, 170);

      // Blending: store a pixel, close the frame, then hit the same pixel back to back.
      apply_setting(1'b1, 9'd128, 4'hF);
      queue_item(pixel_item(7, 0, 0, 16'h1000, 0, 0, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(PIXEL_COUNT - 1, 0, 0, 16'h0200, 0, 0, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(7, 0, 0, 16'h3000, 0, 0, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(7, 0, 0, 16'hFFFF, 0, 0, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(PIXEL_COUNT - 1, 0, 0, 16'hFFFF, 0, 0, STATUS_FMT_RAW, 0));
      queue_item(pixel_item(100000, 0, 0, 16'hBEEF, 0, 0, STATUS_FMT_RAW, 0));
      run_phase(36, 48, 180);

      apply_setting(1'b1, ALPHA_ONE, 4'h7);
      run_phase(36, 48, 190);

      // Receiver now keeps up better than the sender.
      apply_setting(1'b1, 9'd0, 4'hE);
      run_phase(48, 36, 190);
      apply_setting(1'b1, 9'd511, 4'hB);
      run_phase(48, 36, 190);
      apply_setting(1'b0, 9'd200, 4'h0);
      run_phase(48, 36, 190);

      // Full rate on both sides.
      apply_setting(1'b1, 9'd77, 4'h9);
      run_phase(0, 0, 190);
      apply_setting(1'b1, 9'd257, 4'hF);
      run_phase(0, 0, 190);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
